// ===== src/hstk_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hstk_pkg
// Shared types, constants and fixed-point helpers for the knee tone curve.
// ----------------------------------------------------------------------------
package hstk_pkg;

    localparam int FRAC_BITS = 16;
    localparam int SMP_W     = FRAC_BITS + 1;   // sample width, 0 .. 1.0
    localparam int KS_W      = FRAC_BITS;       // knee start register width
    localparam int HC_W      = FRAC_BITS + 2;   // compression register width
    localparam int COEF_W    = FRAC_BITS + 8;   // signed working width
    localparam int PROD_W    = 2 * COEF_W;      // full product width
    localparam int TDATA_W   = ((3 * SMP_W + 7) / 8) * 8;

    // pipeline depth of one lane (stage 0 .. LANE_ST-1); top adds the output register
    localparam int DIV_ST    = FRAC_BITS + 1;   // one quotient bit per stage
    localparam int LANE_ST   = DIV_ST + 6;
    localparam int NST       = LANE_ST + 1;

    localparam longint ONE_L  = longint'(1) << FRAC_BITS;
    localparam longint HALF_L = longint'(1) << (FRAC_BITS - 1);
    localparam longint QA_L   = ((longint'(28188) << FRAC_BITS) + 5000) / 10000;
    localparam longint QB_L   = ((longint'(27718) << FRAC_BITS) + 5000) / 10000;
    localparam longint QC_L   = ((longint'(16812) << FRAC_BITS) + 5000) / 10000;

    typedef logic [SMP_W-1:0]         sample_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    localparam sample_t ONE  = sample_t'(ONE_L);
    localparam sample_t HALF = sample_t'(HALF_L);
    localparam coef_t   C_ONE = coef_t'(ONE_L);
    localparam coef_t   QA   = coef_t'(QA_L);
    localparam coef_t   QB   = coef_t'(QB_L);
    localparam coef_t   QC   = coef_t'(QC_L);
    localparam coef_t   QA2  = coef_t'(2 * QA_L);

    // register indexes of the configuration port
    typedef enum logic [0:0] {
        REG_KNEE_START = 1'b0,
        REG_HL_COMP    = 1'b1
    } reg_idx_t;

    // spline constants derived from the configuration
    typedef struct packed {
        sample_t span;
        coef_t   p0;
        coef_t   m0;
        coef_t   m1;
    } knee_t;

    // per-stage load enables handed to each lane
    typedef struct packed {
        logic [LANE_ST-1:0] ld;
    } lane_ctrl_t;

    // shift right with round to nearest, ties away from zero
    function automatic prod_t rnd_shr(input prod_t v, input int unsigned s);
        prod_t h;
        prod_t m;
        h = prod_t'(1) <<< (s - 1);
        if (v >= 0)
        begin
            return (v + h) >>> s;
        end
        m = -v;
        return -((m + h) >>> s);
    endfunction

    // fixed-point product
    function automatic coef_t rmul(input coef_t a, input coef_t b);
        prod_t p;
        prod_t r;
        p = prod_t'(a) * prod_t'(b);
        r = rnd_shr(p, FRAC_BITS);
        return r[COEF_W-1:0];
    endfunction

    // saturate to [0, 1.0]
    function automatic sample_t sat01(input prod_t v);
        if (v < 0)
        begin
            return '0;
        end
        if (v > prod_t'(ONE_L))
        begin
            return ONE;
        end
        return v[SMP_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== src/hlg_to_sdr_knee_tone_curve.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hlg_to_sdr_knee_tone_curve
// HLG to SDR knee tone curve: three channel lanes plus a merging output stage.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while m_tready is high; each stage has its
//   own load enable, so bubbles collapse and input keeps flowing while the
//   output holds a result, until every stage is full.
// The 17-stage divider (one quotient bit per stage) sets the depth.
// Reset: control and configuration registers reset asynchronously; the knee
//   constants settle after reset or a cfg write once hstk_knee_const refills.
module hlg_to_sdr_knee_tone_curve (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration write port
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_addr,
    input  wire logic [hstk_pkg::HC_W-1:0]      cfg_data,
    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [16:0] red_in, [33:17] green_in, [50:34] blue_in, rest zero
    input  wire logic [hstk_pkg::TDATA_W-1:0]   s_tdata,
    // output stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [16:0] red_out, [33:17] green_out, [50:34] blue_out, rest zero
    output logic [hstk_pkg::TDATA_W-1:0]        m_tdata
);
    import hstk_pkg::*;

    logic [KS_W-1:0]        ks_reg;
    logic signed [HC_W-1:0] hc_reg;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] ld;
    lane_ctrl_t     ctrl;
    knee_t          knee;
    sample_t        y_lane [0:2];
    logic [TDATA_W-1:0] out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ks_reg <= KS_W'(HALF_L);
            hc_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_KNEE_START: ks_reg <= cfg_data[KS_W-1:0];
                REG_HL_COMP:    hc_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // load enable chain: a stage loads when empty or when its successor loads
    always_comb
    begin
        ld[NST-1] = !vld_reg[NST-1] || m_tready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            ld[k] = !vld_reg[k] || ld[k+1];
        end
    end

    assign s_tready = ld[0];
    assign ctrl.ld  = ld[LANE_ST-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ld[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (ld[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    hstk_knee_const u_knee (
        .clk                   (clk),
        .knee_start            (ks_reg),
        .highlight_compression (hc_reg),
        .knee                  (knee)
    );

    // one lane per color channel
    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        hstk_lane u_lane (
            .clk        (clk),
            .ctrl       (ctrl),
            .knee_start (ks_reg),
            .knee       (knee),
            .x_in       (s_tdata[c*SMP_W +: SMP_W]),
            .y_out      (y_lane[c])
        );
    end

    // merge the lane results into the output register
    always_ff @(posedge clk)
    begin
        if (ld[NST-1])
        begin
            out_reg <= TDATA_W'({y_lane[2], y_lane[1], y_lane[0]});
        end
    end

    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = out_reg;

`ifndef NO_ASSERTIONS
    // an empty output stage must never block the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[NST-1] |-> s_tready)
        else $error("input blocked with empty output stage");

    // an accepted transaction occupies the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted transaction lost at stage 0");

    // results are saturated to 1.0
    a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[SMP_W-1:0] <= ONE) && (m_tdata[2*SMP_W-1:SMP_W] <= ONE)
                     && (m_tdata[3*SMP_W-1:2*SMP_W] <= ONE))
        else $error("output channel above 1.0");

    // a taken result with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !vld_reg[NST-2] |=> !m_tvalid)
        else $error("result repeated");
`endif

endmodule
`default_nettype wire

// ===== src/hstk_knee_const.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hstk_knee_const
// Free-running pipeline deriving spline endpoint and slopes from the knee.
// ----------------------------------------------------------------------------
module hstk_knee_const (
    input  wire logic                         clk,
    input  wire logic [hstk_pkg::KS_W-1:0]    knee_start,
    input  wire logic signed [hstk_pkg::HC_W-1:0] highlight_compression,
    output hstk_pkg::knee_t                   knee
);
    import hstk_pkg::*;

    coef_t ks;
    coef_t hc;
    logic  big;

    coef_t kk1_reg, qbk1_reg, gsa1_reg;
    logic  big1_reg, big2_reg;
    coef_t qak2_reg, qbk2_reg, gs2_reg;
    coef_t gk3_reg, gs3_reg;
    coef_t p0_4_reg, kgs4_reg, gk4_reg;
    coef_t p0_5_reg, m0_5_reg;
    coef_t p0_6_reg, m0_6_reg, m1max6_reg;
    coef_t p0_7_reg, m0_7_reg, m1_7_reg;
    sample_t span;
    prod_t lin6;
    prod_t r6;

    assign ks   = coef_t'(knee_start);
    assign hc   = coef_t'(highlight_compression);
    assign big  = ks > coef_t'(HALF_L);
    assign span = ONE - sample_t'(knee_start);

    assign lin6 = prod_t'(coef_t'(6) * C_ONE) - prod_t'(coef_t'(6) * p0_5_reg)
                - prod_t'(coef_t'(2) * m0_5_reg);
    assign r6   = rnd_shr(lin6, 2);

    always_ff @(posedge clk)
    begin
        kk1_reg    <= rmul(ks, ks);
        qbk1_reg   <= rmul(QB, ks);
        gsa1_reg   <= rmul(QA2, ks);
        big1_reg   <= big;

        qak2_reg   <= rmul(QA, kk1_reg);
        qbk2_reg   <= qbk1_reg;
        gs2_reg    <= big1_reg ? gsa1_reg - QB : '0;
        big2_reg   <= big1_reg;

        gk3_reg    <= big2_reg ? qak2_reg - qbk2_reg + QC : C_ONE;
        gs3_reg    <= gs2_reg;

        p0_4_reg   <= rmul(ks, gk3_reg);
        kgs4_reg   <= rmul(ks, gs3_reg);
        gk4_reg    <= gk3_reg;

        p0_5_reg   <= p0_4_reg;
        m0_5_reg   <= rmul(kgs4_reg + gk4_reg, coef_t'(span));

        p0_6_reg   <= p0_5_reg;
        m0_6_reg   <= m0_5_reg;
        m1max6_reg <= r6[COEF_W-1:0];

        p0_7_reg   <= p0_6_reg;
        m0_7_reg   <= m0_6_reg;
        m1_7_reg   <= rmul(hc, m1max6_reg);
    end

    assign knee.span = span;
    assign knee.p0   = p0_7_reg;
    assign knee.m0   = m0_7_reg;
    assign knee.m1   = m1_7_reg;

endmodule
`default_nettype wire

// ===== src/hstk_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hstk_lane
// One channel: quadratic gain path in parallel with a bit-per-stage divider
// feeding the Hermite spline evaluation.
// ----------------------------------------------------------------------------
module hstk_lane (
    input  wire logic                      clk,
    input  wire hstk_pkg::lane_ctrl_t      ctrl,
    input  wire logic [hstk_pkg::KS_W-1:0] knee_start,
    input  wire hstk_pkg::knee_t           knee,
    input  wire logic [hstk_pkg::SMP_W-1:0] x_in,
    output logic [hstk_pkg::SMP_W-1:0]     y_out
);
    import hstk_pkg::*;

    localparam int LIN_ST = 4;   // stage holding the finished quadratic result
    localparam int T_ST   = DIV_ST + 1;

    sample_t xc;
    sample_t x_reg [0:LIN_ST-1];
    logic    knee_reg [0:LANE_ST-2];
    sample_t d0_reg;

    logic [SMP_W:0]   rem_reg [1:DIV_ST];
    logic [SMP_W-1:0] q_reg   [1:DIV_ST];

    coef_t   xx1_reg, qbx1_reg, qbx2_reg, qa2_reg, g3_reg;
    sample_t lin_reg [LIN_ST:LANE_ST-2];
    coef_t   ylin4;

    coef_t t18_reg, t2_18_reg, t19_reg, t2_19_reg, t3_19_reg;
    coef_t h00, h10, h11, h01;
    prod_t pa20_reg, pb20_reg, pc20_reg, sum21_reg;
    coef_t h01_20_reg, h01_21_reg;
    prod_t yk;
    sample_t y_reg;

    assign xc = (x_in > ONE) ? ONE : x_in;

    // input stage
    always_ff @(posedge clk)
    begin
        if (ctrl.ld[0])
        begin
            x_reg[0]    <= xc;
            knee_reg[0] <= xc > sample_t'(knee_start);
            d0_reg      <= xc - sample_t'(knee_start);
        end
    end

    // restoring divider: t = (d << FRAC_BITS) / span
    for (genvar k = 1; k <= DIV_ST; k++)
    begin : g_div
        logic [SMP_W:0]   trial;
        logic [SMP_W-1:0] q_prev;
        logic             bit_q;
        if (k == 1)
        begin : g_first
            assign trial  = {1'b0, d0_reg};
            assign q_prev = '0;
        end
        else
        begin : g_rest
            assign trial  = {rem_reg[k-1][SMP_W-1:0], 1'b0};
            assign q_prev = q_reg[k-1];
        end
        assign bit_q = trial >= {1'b0, knee.span};
        always_ff @(posedge clk)
        begin
            if (ctrl.ld[k])
            begin
                rem_reg[k] <= bit_q ? trial - {1'b0, knee.span} : trial;
                q_reg[k]   <= {q_prev[SMP_W-2:0], bit_q};
            end
        end
    end

    for (genvar k = 1; k <= LANE_ST - 2; k++)
    begin : g_knee
        always_ff @(posedge clk)
        begin
            if (ctrl.ld[k])
            begin
                knee_reg[k] <= knee_reg[k-1];
            end
        end
    end

    // quadratic gain path: x * (QA*x^2 - QB*x + QC) above 0.5, else x
    assign ylin4 = rmul(coef_t'(x_reg[LIN_ST-1]), g3_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.ld[1])
        begin
            x_reg[1] <= x_reg[0];
            xx1_reg  <= rmul(coef_t'(x_reg[0]), coef_t'(x_reg[0]));
            qbx1_reg <= rmul(QB, coef_t'(x_reg[0]));
        end
        if (ctrl.ld[2])
        begin
            x_reg[2] <= x_reg[1];
            qa2_reg  <= rmul(QA, xx1_reg);
            qbx2_reg <= qbx1_reg;
        end
        if (ctrl.ld[3])
        begin
            x_reg[3] <= x_reg[2];
            g3_reg   <= (x_reg[2] > HALF) ? qa2_reg - qbx2_reg + QC : C_ONE;
        end
        if (ctrl.ld[LIN_ST])
        begin
            lin_reg[LIN_ST] <= sat01(prod_t'(ylin4));
        end
    end

    for (genvar k = LIN_ST + 1; k <= LANE_ST - 2; k++)
    begin : g_lin
        always_ff @(posedge clk)
        begin
            if (ctrl.ld[k])
            begin
                lin_reg[k] <= lin_reg[k-1];
            end
        end
    end

    // Hermite basis and weighted sum
    assign h00 = coef_t'(2) * t3_19_reg - coef_t'(3) * t2_19_reg + C_ONE;
    assign h10 = t3_19_reg - coef_t'(2) * t2_19_reg + t19_reg;
    assign h11 = t3_19_reg - t2_19_reg;
    assign h01 = coef_t'(3) * t2_19_reg - coef_t'(2) * t3_19_reg;
    assign yk  = rnd_shr(sum21_reg, FRAC_BITS) + prod_t'(h01_21_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.ld[T_ST])
        begin
            t18_reg   <= coef_t'(q_reg[DIV_ST]);
            t2_18_reg <= rmul(coef_t'(q_reg[DIV_ST]), coef_t'(q_reg[DIV_ST]));
        end
        if (ctrl.ld[T_ST+1])
        begin
            t19_reg   <= t18_reg;
            t2_19_reg <= t2_18_reg;
            t3_19_reg <= rmul(t2_18_reg, t18_reg);
        end
        if (ctrl.ld[T_ST+2])
        begin
            pa20_reg   <= prod_t'(h00) * prod_t'(knee.p0);
            pb20_reg   <= prod_t'(h10) * prod_t'(knee.m0);
            pc20_reg   <= prod_t'(h11) * prod_t'(knee.m1);
            h01_20_reg <= h01;
        end
        if (ctrl.ld[T_ST+3])
        begin
            sum21_reg  <= pa20_reg + pb20_reg + pc20_reg;
            h01_21_reg <= h01_20_reg;
        end
        if (ctrl.ld[LANE_ST-1])
        begin
            y_reg <= knee_reg[LANE_ST-2] ? sat01(yk) : lin_reg[LANE_ST-2];
        end
    end

    assign y_out = y_reg;

endmodule
`default_nettype wire
